// File: src/wsd_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared types, codes and helper functions for the frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  // Header parser phases.
  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTHI,
    PH_EXTLO,
    PH_MASK,
    PH_DATA
  } phase_t;

  // Kinds of command passed from the parser to the output stage.
  typedef enum logic [1:0] {
    CMD_DATA,
    CMD_MARK,
    CMD_ERR
  } cmd_kind_t;

  // Frame status codes.
  localparam logic [2:0] ST_TEXT      = 3'd0;
  localparam logic [2:0] ST_PING      = 3'd1;
  localparam logic [2:0] ST_CLOSE     = 3'd2;
  localparam logic [2:0] ST_OTHER     = 3'd3;
  localparam logic [2:0] ST_UNMASKED  = 3'd4;
  localparam logic [2:0] ST_FIN_CLEAR = 3'd5;
  localparam logic [2:0] ST_LEN64     = 3'd6;
  localparam logic [2:0] ST_TOO_LONG  = 3'd7;

  // Opcodes that get a class of their own.
  localparam logic [3:0] OPC_TEXT  = 4'h1;
  localparam logic [3:0] OPC_CLOSE = 4'h8;
  localparam logic [3:0] OPC_PING  = 4'h9;

  // Seven-bit length codes that announce an extended length.
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  // Frame buffer limit and header sizes that count against it.
  localparam int FRAME_BUF_LIMIT = 4200;
  localparam int HDR_SHORT_BYTES = 6;
  localparam int HDR_EXT_BYTES   = 8;

  // Configuration register.
  localparam int         MAXP_W        = 13;
  localparam logic [12:0] MAX_PAYLOAD_RST = 13'd4095;

  // Payload byte counter; the largest accepted payload fits in 13 bits.
  localparam int BC_W = 13;

  // Index of the last mask key byte.
  localparam logic [1:0] MASK_LAST_IDX = 2'd3;

  // Two-entry queues between and after the stages.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // Command from the parser to the output stage.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  raw;
    logic [7:0]  key;
    logic        last;
    logic [3:0]  opcode;
    logic [2:0]  err;
    logic [15:0] length;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        frame_last;
    logic [2:0]  frame_status;
    logic [15:0] payload_length;
  } res_t;

  // Maps an opcode to its frame class.
  function automatic logic [2:0] frame_class(input logic [3:0] opcode);
    logic [2:0] cls;
    unique case (opcode)
      OPC_TEXT:  cls = ST_TEXT;
      OPC_PING:  cls = ST_PING;
      OPC_CLOSE: cls = ST_CLOSE;
      default:   cls = ST_OTHER;
    endcase
    return cls;
  endfunction

endpackage

// File: src/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Takes a client-to-server byte stream one byte per transfer, parses each
// frame header and delivers unmasked payload bytes, empty-frame markers and
// header errors as results. The parser takes one byte every clock cycle
// while full is low; an accepted byte is registered in the command queue,
// and its result is then registered in the result queue before it can be
// taken from the out_ ports. full rises only once four results wait
// untaken, two in each queue, so a consumer that keeps pop high never stalls
// the input. max_payload is written through cfg_we and cfg_wdata; the user
// must write it only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  in_byte,
  input  logic                        in_restart,
  output logic                        empty,
  input  logic                        pop,
  output logic [7:0]                  out_data_byte,
  output logic                        out_data_valid,
  output logic                        out_frame_last,
  output logic [2:0]                  out_frame_status,
  output logic [15:0]                 out_payload_length,
  input  logic                        cfg_we,
  input  logic [wsd_pkg::MAXP_W-1:0]  cfg_wdata
);

  logic          acc;
  logic          cmd_push;
  wsd_pkg::cmd_t cmd_in;
  wsd_pkg::cmd_t cmd_head;
  logic          cmd_empty;
  logic          cmd_pop;
  wsd_pkg::res_t res;

  // An input transfer completes when push meets free queue space.
  assign acc = push && !full;

  wsd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .in_byte    (in_byte),
    .in_restart (in_restart),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in)
  );

  wsd_cmdq u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (cmd_head),
    .empty (cmd_empty)
  );

  wsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .res       (res)
  );

  // Result fields onto the output ports.
  assign out_data_byte      = res.data_byte;
  assign out_data_valid     = res.data_valid;
  assign out_frame_last     = res.frame_last;
  assign out_frame_status   = res.frame_status;
  assign out_payload_length = res.payload_length;

endmodule

// File: src/wsd_front.sv
// ----------------------------------------------------------------------------
// WebSocket deframer front end
// Parses the header byte by byte, checks it and issues one command for
// every byte that causes a result.
// ----------------------------------------------------------------------------
module wsd_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        acc,
  input  logic [7:0]                  in_byte,
  input  logic                        in_restart,
  input  logic                        cfg_we,
  input  logic [wsd_pkg::MAXP_W-1:0]  cfg_wdata,
  output logic                        cmd_push,
  output wsd_pkg::cmd_t               cmd
);

  wsd_pkg::phase_t             phase_r, phase_nxt;
  logic                        stopped_r, stopped_nxt;
  logic                        fin_r, fin_nxt;
  logic [3:0]                  opcode_r, opcode_nxt;
  logic [15:0]                 length_r, length_nxt;
  logic [31:0]                 key_r, key_nxt;
  logic [wsd_pkg::BC_W-1:0]    bc_r, bc_nxt;
  logic [wsd_pkg::MAXP_W-1:0]  max_r, max_nxt;

  wsd_pkg::phase_t p_eff;
  logic            stp_eff;
  logic [6:0]      len7;
  logic [15:0]     len16;
  logic            long7;
  logic            long16;
  logic            hdr1_errv;
  logic [2:0]      hdr1_code;
  logic            mask_done;
  logic            data_last;
  logic [7:0]      key_sel;

  // Decode of the current byte against the parser state.
  always_comb begin
    p_eff   = in_restart ? wsd_pkg::PH_HDR0 : phase_r;
    stp_eff = in_restart ? 1'b0 : stopped_r;
    len7    = in_byte[6:0];
    len16   = {length_r[15:8], in_byte};
    long7   = ({6'd0, len7} > max_r) ||
              (14'({7'd0, len7}) + 14'(wsd_pkg::HDR_SHORT_BYTES) >
               14'(wsd_pkg::FRAME_BUF_LIMIT));
    long16  = (len16 > {3'd0, max_r}) ||
              (17'(len16) + 17'(wsd_pkg::HDR_EXT_BYTES) > 17'(wsd_pkg::FRAME_BUF_LIMIT));
    hdr1_errv = 1'b1;
    hdr1_code = wsd_pkg::ST_TOO_LONG;
    priority if (!in_byte[7]) begin
      hdr1_code = wsd_pkg::ST_UNMASKED;
    end else if (!fin_r) begin
      hdr1_code = wsd_pkg::ST_FIN_CLEAR;
    end else if (len7 == wsd_pkg::LEN7_EXT64) begin
      hdr1_code = wsd_pkg::ST_LEN64;
    end else if (len7 != wsd_pkg::LEN7_EXT16 && long7) begin
      hdr1_code = wsd_pkg::ST_TOO_LONG;
    end else begin
      hdr1_errv = 1'b0;
    end
    mask_done = (bc_r[1:0] == wsd_pkg::MASK_LAST_IDX);
    data_last = (16'(bc_r) + 16'd1) >= length_r;
    unique case (bc_r[1:0])
      2'd0:    key_sel = key_r[31:24];
      2'd1:    key_sel = key_r[23:16];
      2'd2:    key_sel = key_r[15:8];
      default: key_sel = key_r[7:0];
    endcase
  end

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (acc && !stp_eff) begin
      unique case (p_eff)
        wsd_pkg::PH_HDR0: begin
          phase_nxt = wsd_pkg::PH_HDR1;
        end
        wsd_pkg::PH_HDR1: begin
          if (hdr1_errv) begin
            phase_nxt = wsd_pkg::PH_HDR0;
          end else if (len7 == wsd_pkg::LEN7_EXT16) begin
            phase_nxt = wsd_pkg::PH_EXTHI;
          end else begin
            phase_nxt = wsd_pkg::PH_MASK;
          end
        end
        wsd_pkg::PH_EXTHI: begin
          phase_nxt = wsd_pkg::PH_EXTLO;
        end
        wsd_pkg::PH_EXTLO: begin
          phase_nxt = long16 ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_MASK;
        end
        wsd_pkg::PH_MASK: begin
          if (mask_done) begin
            phase_nxt = (length_r == 16'd0) ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_DATA;
          end
        end
        wsd_pkg::PH_DATA: begin
          if (data_last) begin
            phase_nxt = wsd_pkg::PH_HDR0;
          end
        end
        default: begin
          phase_nxt = wsd_pkg::PH_HDR0;
        end
      endcase
    end else if (acc) begin
      phase_nxt = p_eff;
    end
  end

  // Header registers, counters and the command to the output stage.
  always_comb begin
    stopped_nxt = stopped_r;
    fin_nxt     = fin_r;
    opcode_nxt  = opcode_r;
    length_nxt  = length_r;
    key_nxt     = key_r;
    bc_nxt      = bc_r;
    max_nxt     = cfg_we ? cfg_wdata : max_r;
    cmd_push    = 1'b0;
    cmd         = '0;
    cmd.kind    = wsd_pkg::CMD_ERR;
    cmd.opcode  = opcode_r;
    if (acc) begin
      if (in_restart) begin
        stopped_nxt = 1'b0;
        bc_nxt      = '0;
      end
      if (!stp_eff) begin
        unique case (p_eff)
          wsd_pkg::PH_HDR0: begin
            fin_nxt    = in_byte[7];
            opcode_nxt = in_byte[3:0];
          end
          wsd_pkg::PH_HDR1: begin
            if (hdr1_errv) begin
              stopped_nxt = 1'b1;
              bc_nxt      = '0;
              cmd_push    = 1'b1;
              cmd.last    = 1'b1;
              cmd.err     = hdr1_code;
              if (hdr1_code == wsd_pkg::ST_TOO_LONG) begin
                length_nxt = {9'd0, len7};
                cmd.length = {9'd0, len7};
              end
            end else if (len7 == wsd_pkg::LEN7_EXT16) begin
              length_nxt = 16'd0;
            end else begin
              length_nxt = {9'd0, len7};
              bc_nxt     = '0;
            end
          end
          wsd_pkg::PH_EXTHI: begin
            length_nxt = {in_byte, 8'h00};
          end
          wsd_pkg::PH_EXTLO: begin
            length_nxt = len16;
            bc_nxt     = '0;
            if (long16) begin
              stopped_nxt = 1'b1;
              cmd_push    = 1'b1;
              cmd.last    = 1'b1;
              cmd.err     = wsd_pkg::ST_TOO_LONG;
              cmd.length  = len16;
            end
          end
          wsd_pkg::PH_MASK: begin
            key_nxt = {key_r[23:0], in_byte};
            if (mask_done) begin
              bc_nxt = '0;
              if (length_r == 16'd0) begin
                cmd_push = 1'b1;
                cmd.kind = wsd_pkg::CMD_MARK;
                cmd.last = 1'b1;
              end
            end else begin
              bc_nxt = bc_r + 1'b1;
            end
          end
          wsd_pkg::PH_DATA: begin
            cmd_push   = 1'b1;
            cmd.kind   = wsd_pkg::CMD_DATA;
            cmd.raw    = in_byte;
            cmd.key    = key_sel;
            cmd.last   = data_last;
            cmd.length = length_r;
            bc_nxt     = data_last ? '0 : bc_r + 1'b1;
          end
          default: begin
            bc_nxt = '0;
          end
        endcase
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= wsd_pkg::PH_HDR0;
      stopped_r <= 1'b0;
      fin_r     <= 1'b0;
      opcode_r  <= '0;
      length_r  <= '0;
      key_r     <= '0;
      bc_r      <= '0;
      max_r     <= wsd_pkg::MAX_PAYLOAD_RST;
    end else begin
      phase_r   <= phase_nxt;
      stopped_r <= stopped_nxt;
      fin_r     <= fin_nxt;
      opcode_r  <= opcode_nxt;
      length_r  <= length_nxt;
      key_r     <= key_nxt;
      bc_r      <= bc_nxt;
      max_r     <= max_nxt;
    end
  end

endmodule

// File: src/wsd_cmdq.sv
// ----------------------------------------------------------------------------
// WebSocket deframer command queue
// Two-entry queue that decouples the header parser from the output stage.
// ----------------------------------------------------------------------------
module wsd_cmdq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  wsd_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output wsd_pkg::cmd_t dout,
  output logic          empty
);

  wsd_pkg::cmd_t                mem_r [wsd_pkg::Q_DEPTH];
  logic [wsd_pkg::Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [wsd_pkg::Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [wsd_pkg::Q_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                         do_push;
  logic                         do_pop;

  // Status and pointer updates.
  always_comb begin
    full       = (cnt_r == wsd_pkg::Q_CNT_W'(wsd_pkg::Q_DEPTH));
    empty      = (cnt_r == '0);
    do_push    = push && !full;
    do_pop     = pop && !empty;
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + wsd_pkg::Q_CNT_W'(do_push) - wsd_pkg::Q_CNT_W'(do_pop);
    dout       = mem_r[rd_ptr_r];
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: src/wsd_back.sv
// ----------------------------------------------------------------------------
// WebSocket deframer back end
// Unmasks payload bytes, resolves the frame status and holds finished
// results in a two-entry output queue.
// ----------------------------------------------------------------------------
module wsd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_empty,
  input  wsd_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          pop,
  output logic          empty,
  output wsd_pkg::res_t res
);

  wsd_pkg::res_t                mem_r [wsd_pkg::Q_DEPTH];
  logic [wsd_pkg::Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [wsd_pkg::Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [wsd_pkg::Q_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                         full;
  logic                         do_pop;
  wsd_pkg::res_t                res_new;

  // Result formatting for the command at the head of the command queue.
  always_comb begin
    res_new                = '0;
    res_new.frame_last     = cmd.last;
    res_new.payload_length = cmd.length;
    unique case (cmd.kind)
      wsd_pkg::CMD_DATA: begin
        res_new.data_byte    = cmd.raw ^ cmd.key;
        res_new.data_valid   = 1'b1;
        res_new.frame_status = wsd_pkg::frame_class(cmd.opcode);
      end
      wsd_pkg::CMD_MARK: begin
        res_new.frame_status = wsd_pkg::frame_class(cmd.opcode);
      end
      default: begin
        res_new.frame_status = cmd.err;
      end
    endcase
  end

  // Output queue control.
  always_comb begin
    full       = (cnt_r == wsd_pkg::Q_CNT_W'(wsd_pkg::Q_DEPTH));
    empty      = (cnt_r == '0);
    cmd_pop    = !cmd_empty && !full;
    do_pop     = pop && !empty;
    wr_ptr_nxt = cmd_pop ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + wsd_pkg::Q_CNT_W'(cmd_pop) - wsd_pkg::Q_CNT_W'(do_pop);
    res        = mem_r[rd_ptr_r];
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      mem_r[wr_ptr_r] <= res_new;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: src/wsd_checker.sv
// ----------------------------------------------------------------------------
// WebSocket deframer port checker
// Watches the top-level ports for result consistency and result hold.
// ----------------------------------------------------------------------------
module wsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  out_data_byte,
  input logic        out_data_valid,
  input logic        out_frame_last,
  input logic [2:0]  out_frame_status,
  input logic [15:0] out_payload_length
);

  // A result without payload data always closes a frame.
  a_nodata_last: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_data_valid |-> out_frame_last && out_data_byte == 8'd0)
    else $error("result without data is not a frame end");

  // Error codes never travel with payload data.
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_frame_status[2] |-> !out_data_valid && out_frame_last)
    else $error("error result carries data");

  // Errors other than too long report a zero length.
  a_err_len: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_frame_status[2] && out_frame_status != wsd_pkg::ST_TOO_LONG
    |-> out_payload_length == 16'd0)
    else $error("header error with nonzero length");

  // A waiting result stays put until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_data_byte) && $stable(out_frame_status)
    && $stable(out_payload_length))
    else $error("waiting result changed");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .empty              (empty),
  .pop                (pop),
  .out_data_byte      (out_data_byte),
  .out_data_valid     (out_data_valid),
  .out_frame_last     (out_frame_last),
  .out_frame_status   (out_frame_status),
  .out_payload_length (out_payload_length)
);
